[design/spw_pkg.sv]
// spw_pkg: word types, request codes and frame constants for the three-wire
// pot wiper transactor; used by the channel interfaces and every module
package spw_pkg;

   // request codes
   localparam logic [1:0] FUNC_TICK       = 2'd0;
   localparam logic [1:0] FUNC_WRITE_WIPER = 2'd1;
   localparam logic [1:0] FUNC_WRITE_TCON  = 2'd2;
   localparam logic [1:0] FUNC_READ_WIPER  = 2'd3;

   // command bytes
   localparam logic [7:0] CMD_WRITE_VOL   = 8'h00;
   localparam logic [7:0] CMD_NV_ADDR     = 8'h20;
   localparam logic [7:0] CMD_WRITE_TCON  = 8'h40;
   localparam logic [7:0] CMD_READ_VOL    = 8'h0c;
   localparam logic [7:0] CMD_READ_NV     = 8'h2c;

   // half-phase positions in the 16-bit frame
   localparam int PHASE_WIDTH = 5;
   localparam logic [PHASE_WIDTH-1:0] LAST_PHASE   = 5'd31;
   localparam logic [PHASE_WIDTH-1:0] CMDERR_PHASE = 5'd13;
   localparam logic [3:0] CMDERR_SLOT   = 4'd6;
   localparam logic [3:0] DATA8_SLOT    = 4'd7;

   typedef struct packed {
      logic [1:0] func;
      logic       nonvolatile;
      logic       target_heat;
      logic [8:0] value_in;
      logic       line_in;
   } req_word_type;

   typedef struct packed {
      logic        sck;
      logic        line_out;
      logic        cs_heat_n;
      logic        cs_other_n;
      logic        busy_res;
      logic        done_res;
      logic        ok;
      logic [15:0] read_value;
   } rsp_word_type;

endpackage

[design/spw_channels.sv]
// spw_channels: valid/ready channel interfaces for request and response words
// depends on spw_pkg for the word types
interface spw_req_if;
   import spw_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface spw_rsp_if;
   import spw_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[design/spw_frame_core.sv]
// spw_frame_core: frame state registers and the per-half-phase step logic
// depends on spw_pkg
module spw_frame_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  spw_pkg::req_word_type req_word,
   output spw_pkg::rsp_word_type rsp_word
);
   import spw_pkg::*;

   logic                   active_ff, active_in;
   logic [PHASE_WIDTH-1:0] phase_ff, phase_in;
   logic [15:0]            frame_ff, frame_in;
   logic [1:0]             op_ff, op_in;
   logic                   heat_ff, heat_in;

   logic [3:0]  slot;
   logic [3:0]  bit_idx;
   logic [15:0] frame_rx;
   logic [7:0]  cmd;
   logic [7:0]  data;

   // outputs while a frame is running, for phase p of frame f
   function automatic rsp_word_type frame_out(input logic [PHASE_WIDTH-1:0] p,
                                              input logic [15:0] f,
                                              input logic [1:0] op,
                                              input logic heat);
      rsp_word_type r;
      logic [3:0]   s;
      logic [3:0]   idx;
      s   = p[PHASE_WIDTH-1:1];
      idx = ~s;
      r   = '0;
      r.sck = p[0];
      if (s < CMDERR_SLOT) begin
         r.line_out = f[idx];
      end else if (s == CMDERR_SLOT || op == FUNC_READ_WIPER) begin
         r.line_out = 1'b1;
      end else begin
         r.line_out = f[idx];
      end
      r.cs_heat_n  = ~heat;
      r.cs_other_n = heat;
      r.busy_res   = 1'b1;
      return r;
   endfunction

   // idle bus levels
   function automatic rsp_word_type idle_out();
      rsp_word_type r;
      r            = '0;
      r.line_out   = 1'b1;
      r.cs_heat_n  = 1'b1;
      r.cs_other_n = 1'b1;
      return r;
   endfunction

   assign slot    = phase_ff[PHASE_WIDTH-1:1];
   assign bit_idx = ~slot;

   // receive bit sampled in high half of data slots on reads
   always_comb begin
      frame_rx = frame_ff;
      if (op_ff == FUNC_READ_WIPER && phase_ff[0] && slot >= DATA8_SLOT
          && req_word.line_in) begin
         frame_rx[bit_idx] = 1'b1;
      end
   end

   // command and data bytes for a new request
   always_comb begin
      case (req_word.func)
         FUNC_WRITE_WIPER: begin
            cmd  = (req_word.nonvolatile ? CMD_NV_ADDR : CMD_WRITE_VOL)
                   | {7'd0, req_word.value_in[8]};
            data = req_word.value_in[7:0];
         end
         FUNC_WRITE_TCON: begin
            cmd  = CMD_WRITE_TCON;
            data = req_word.value_in[7:0];
         end
         FUNC_READ_WIPER: begin
            cmd  = req_word.nonvolatile ? CMD_READ_NV : CMD_READ_VOL;
            data = 8'h00;
         end
         default: begin
            cmd  = 8'h00;
            data = 8'h00;
         end
      endcase
   end

   // step: next state and result word
   always_comb begin
      active_in = active_ff;
      phase_in  = phase_ff;
      frame_in  = frame_ff;
      op_in     = op_ff;
      heat_in   = heat_ff;
      rsp_word  = idle_out();
      if (active_ff) begin
         if (phase_ff == CMDERR_PHASE && !req_word.line_in) begin
            active_in         = 1'b0;
            phase_in          = '0;
            rsp_word.done_res = 1'b1;
         end else begin
            frame_in = frame_rx;
            if (phase_ff == LAST_PHASE) begin
               active_in           = 1'b0;
               phase_in            = '0;
               rsp_word.done_res   = 1'b1;
               rsp_word.ok         = 1'b1;
               rsp_word.read_value = (op_ff == FUNC_READ_WIPER) ? frame_rx : 16'h0000;
            end else begin
               phase_in = phase_ff + 1'b1;
               rsp_word = frame_out(phase_ff + 1'b1, frame_rx, op_ff, heat_ff);
            end
         end
      end else if (req_word.func != FUNC_TICK) begin
         active_in = 1'b1;
         phase_in  = '0;
         frame_in  = {cmd, data};
         op_in     = req_word.func;
         heat_in   = req_word.target_heat;
         rsp_word  = frame_out('0, {cmd, data}, req_word.func, req_word.target_heat);
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         phase_ff  <= '0;
         frame_ff  <= '0;
         op_ff     <= FUNC_TICK;
         heat_ff   <= 1'b0;
      end else if (step_en) begin
         active_ff <= active_in;
         phase_ff  <= phase_in;
         frame_ff  <= frame_in;
         op_ff     <= op_in;
         heat_ff   <= heat_in;
      end
   end

endmodule

[design/spw_out_stage.sv]
// spw_out_stage: response word register with valid/ready handshake
// depends on spw_pkg
module spw_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  spw_pkg::rsp_word_type word_in,
   output logic                  can_load,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output spw_pkg::rsp_word_type rsp_word
);
   import spw_pkg::*;

   logic         valid_ff;
   rsp_word_type word_ff;

   // room when empty or the held word leaves this cycle
   assign can_load  = ~valid_ff | rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

endmodule

[design/spi_pot_wiper_transactor.sv]
// spi_pot_wiper_transactor: three-wire SPI mode 0 master for a digital pot
// latency: a request word's response word is valid the cycle after acceptance
// throughput: one word per cycle if rsp ready; output reg refills while taken
// a word is a serial-clock half-phase; a frame is 32 of them plus a done word
// reset (synchronous, active high) returns to idle with no response pending
// depends on spw_pkg, spw_channels, spw_frame_core, spw_out_stage
module spi_pot_wiper_transactor (
   input logic       clock,
   input logic       reset,
   spw_req_if.sink   req_chan,
   spw_rsp_if.source rsp_chan
);
   import spw_pkg::*;

   logic         step_en;
   logic         can_load;
   rsp_word_type step_word;

   assign req_chan.ready = can_load;
   assign step_en        = req_chan.valid & can_load;

   // frame state and step logic
   spw_frame_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step_en  (step_en),
      .req_word (req_chan.data),
      .rsp_word (step_word)
   );

   // response register
   spw_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (step_en),
      .word_in   (step_word),
      .can_load  (can_load),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_word  (rsp_chan.data)
   );

endmodule
